// ===== sv/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    localparam int IDX_W   = 3;
    localparam int T_W     = 17;
    localparam int CNT_W   = 4;
    localparam int FRAC_W  = 16;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

endpackage

// ===== sv/bezier_curve_point_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core
// De Casteljau evaluation of a Bezier curve, one lerp level per two stages.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// s_      | in  | point_index, point_x, point_y, param_t      | op
// m_      | out | curve_x, curve_y                            | -
// cfg_    | in  | point_count (4 bits)                        | -
//
// Each evaluate word passes an entry stage and then 2*(MAX_POINTS-1) register
// stages, one multiply stage and one add stage per interpolation level; one
// word can enter per cycle while m_ is not stalled. Control points are copied
// into the pipe on entry, so later loads do not touch words in flight. Loads
// give no output. Reset clears valid bits and point_count. A stall on m_
// freezes the whole pipe.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator_core
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int COORD_BITS = 16,
    localparam int S_TDW = ((IDX_W + 2 * COORD_BITS + T_W) + 7) / 8 * 8,
    localparam int M_TDW = ((2 * COORD_BITS) + 7) / 8 * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_index, point_x, point_y, param_t, zero pad
    input  logic [S_TDW-1:0]     s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // curve_x, curve_y, zero pad
    output logic [M_TDW-1:0]     m_tdata
);

    localparam int LV    = MAX_POINTS - 1;
    localparam int NST   = 2 * LV;
    localparam int IW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = DW + T_W + 1;

    typedef logic signed [COORD_BITS-1:0] crd_t;
    typedef logic signed [DW-1:0]         dif_t;

    logic [CNT_W-1:0] count_reg;
    crd_t             mem_x_reg [MAX_POINTS];
    crd_t             mem_y_reg [MAX_POINTS];

    logic             vld_reg [NST+1];
    logic [T_W-1:0]   t_reg   [NST+1];
    logic [NW-1:0]    n_reg   [NST+1];
    crd_t             px_reg  [LV+1][MAX_POINTS];
    crd_t             py_reg  [LV+1][MAX_POINTS];
    crd_t             ax_reg  [1:LV][MAX_POINTS];
    crd_t             ay_reg  [1:LV][MAX_POINTS];
    dif_t             mx_reg  [1:LV][MAX_POINTS];
    dif_t             my_reg  [1:LV][MAX_POINTS];

    logic [IDX_W-1:0]      in_idx;
    crd_t                  in_x, in_y;
    logic [T_W-1:0]        in_t, t_sat;
    logic [NW-1:0]         n_act;
    logic                  adv, acc, acc_eval, acc_load;
    logic [IW-1:0]         widx;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_x   = s_tdata[IDX_W +: COORD_BITS];
    assign in_y   = s_tdata[IDX_W+COORD_BITS +: COORD_BITS];
    assign in_t   = s_tdata[IDX_W+2*COORD_BITS +: T_W];
    assign t_sat  = (in_t > T_ONE) ? T_ONE : in_t;
    assign widx   = IW'(in_idx);

    always_comb begin
        if (32'(count_reg) > MAX_POINTS) begin
            n_act = NW'(MAX_POINTS);
        end else begin
            n_act = NW'(count_reg);
        end
    end

    assign adv      = !vld_reg[NST] || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;
    assign acc_eval = acc && (op_t'(s_tuser) == OP_EVAL) && (n_act >= NW'(2));
    assign acc_load = acc && (op_t'(s_tuser) == OP_LOAD)
                      && (32'(in_idx) < 32'(n_act));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_load) begin
            mem_x_reg[widx] <= in_x;
            mem_y_reg[widx] <= in_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NST; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= acc_eval;
            for (int k = 1; k <= NST; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // level j: odd stage 2j-1 holds a and (b-a)*t>>>16, even stage 2j the lerp
    always_ff @(posedge aclk) begin
        logic signed [PW-1:0] prx, pry;
        dif_t                 dx, dy;
        int                   nx;
        if (adv) begin
            t_reg[0] <= t_sat;
            n_reg[0] <= n_act;
            for (int i = 0; i < MAX_POINTS; i++) begin
                px_reg[0][i] <= mem_x_reg[i];
                py_reg[0][i] <= mem_y_reg[i];
            end
            for (int k = 1; k <= NST; k++) begin
                t_reg[k] <= t_reg[k-1];
                n_reg[k] <= n_reg[k-1];
            end
            for (int j = 1; j <= LV; j++) begin
                for (int i = 0; i < MAX_POINTS; i++) begin
                    nx = (i < MAX_POINTS - 1) ? i + 1 : i;
                    ax_reg[j][i] <= px_reg[j-1][i];
                    ay_reg[j][i] <= py_reg[j-1][i];
                    if (i < MAX_POINTS - 1) begin
                        dx  = DW'(px_reg[j-1][nx]) - DW'(px_reg[j-1][i]);
                        dy  = DW'(py_reg[j-1][nx]) - DW'(py_reg[j-1][i]);
                        prx = PW'(dx) * $signed({1'b0, t_reg[2*j-2]});
                        pry = PW'(dy) * $signed({1'b0, t_reg[2*j-2]});
                        mx_reg[j][i] <= prx[FRAC_W +: DW];
                        my_reg[j][i] <= pry[FRAC_W +: DW];
                    end else begin
                        mx_reg[j][i] <= '0;
                        my_reg[j][i] <= '0;
                    end
                    if (32'(n_reg[2*j-1]) > j) begin
                        px_reg[j][i] <= COORD_BITS'(DW'(ax_reg[j][i]) + mx_reg[j][i]);
                        py_reg[j][i] <= COORD_BITS'(DW'(ay_reg[j][i]) + my_reg[j][i]);
                    end else begin
                        px_reg[j][i] <= ax_reg[j][i];
                        py_reg[j][i] <= ay_reg[j][i];
                    end
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NST];
    assign m_tdata  = M_TDW'({py_reg[LV][0], px_reg[LV][0]});

    a_load_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && op_t'(s_tuser) == OP_LOAD) |=> !vld_reg[0])
        else $error("load entered pipe");

    a_short_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && n_act < NW'(2)) |=> !vld_reg[0])
        else $error("evaluate with under two points entered pipe");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && !$past(s_tready)))
        else $error("pipe moved during stall");

endmodule

// ===== tb/bezier_curve_point_evaluator_core_tb.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core_tb
// Self-checking bench for the De Casteljau point evaluator. Control points
// are loaded and curves are evaluated over a series of point counts. A
// bit-exact curve predictor in the bench builds the expected points, and a
// monitor compares each output word with the oldest one. Both sides idle at
// random outside two full-rate phases, and there is one long output stall.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator_core_tb;
    import bcpe_pkg::*;

    localparam int NPTS      = 8;
    localparam int S_W       = 56;
    localparam int M_W       = 32;
    localparam int WD_LIMIT  = 5000;
    localparam int HOLD_LEN  = 300;
    localparam int HOLD_PH   = 4;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [15:0]      px;
        logic [15:0]      py;
        logic [T_W-1:0]   t;
    } bez_word_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
    } curve_pt_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;

    bez_word_t  word_q[$];
    curve_pt_t  curve_q[$];
    logic [15:0] pt_x[NPTS];
    logic [15:0] pt_y[NPTS];
    logic [CNT_W-1:0] count_reg;
    logic       s_fire;
    int         mismatches;
    int         n_loads, n_evals, n_curves;
    int         phase_num;
    int         idle_cnt;
    int         hold_cnt;
    bit         hold_done;

    bezier_curve_point_evaluator_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic int active_points(input logic [CNT_W-1:0] c);
        return (c > NPTS) ? NPTS : int'(c);
    endfunction

    function automatic curve_pt_t eval_curve(input logic [T_W-1:0] t_in, input int n);
        longint ax[NPTS];
        longint ay[NPTS];
        longint t;
        curve_pt_t r;
        t = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
        for (int i = 0; i < n; i++) begin
            ax[i] = longint'($signed(pt_x[i]));
            ay[i] = longint'($signed(pt_y[i]));
        end
        for (int j = 1; j < n; j++)
            for (int i = 0; i + j < n; i++) begin
                ax[i] = ax[i] + (((ax[i+1] - ax[i]) * t) >>> 16);
                ay[i] = ay[i] + (((ay[i+1] - ay[i]) * t) >>> 16);
            end
        r.cx = ax[0][15:0];
        r.cy = ay[0][15:0];
        return r;
    endfunction

    // accept side: predictor and config shadow
    always @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (cfg_wr_en) count_reg <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    n_loads++;
                    if (int'(s_tdata[2:0]) < active_points(count_reg)) begin
                        pt_x[s_tdata[2:0]] = s_tdata[18:3];
                        pt_y[s_tdata[2:0]] = s_tdata[34:19];
                    end
                end else begin
                    n_evals++;
                    if (active_points(count_reg) >= 2)
                        curve_q.insert(curve_q.size(),
                                       eval_curve(s_tdata[51:35],
                                                  active_points(count_reg)));
                end
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        bez_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (word_q.size() != 0 && (phase_num == 6 || phase_num == 7 ||
                                       $urandom_range(99) >= 31)) begin
                w = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.op;
                s_tdata  <= {4'b0, w.t, w.py, w.px, w.idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (phase_num == HOLD_PH && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
        end else begin
            m_tready <= (phase_num == 6 || phase_num == 7) ? 1'b1
                                                            : ($urandom_range(99) >= 31);
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        curve_pt_t e;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WD_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", WD_LIMIT);
                $display("FAIL bezier_curve_point_evaluator_core");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (curve_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    e = curve_q.pop_front();
                    n_curves++;
                    if (m_tdata[15:0] !== e.cx)
                        report_mismatch($sformatf("curve_x %h exp %h", m_tdata[15:0], e.cx));
                    if (m_tdata[31:16] !== e.cy)
                        report_mismatch($sformatf("curve_y %h exp %h", m_tdata[31:16], e.cy));
                end
            end
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_param();
        case ($urandom_range(11))
            0: return '0;
            1: return T_ONE;
            2: return T_ONE + 17'd1;
            3: return '1;
            4: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic push_word(input op_t op, input int idx, input logic [15:0] x,
                             input logic [15:0] y, input logic [T_W-1:0] t);
        bez_word_t w;
        w.op = op; w.idx = IDX_W'(idx); w.px = x; w.py = y; w.t = t;
        word_q.insert(word_q.size(), w);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] c);
        while (word_q.size() != 0 || s_tvalid || curve_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    logic [CNT_W-1:0] counts[14] = '{8, 0, 1, 2, 15, 3, 8, 5, 9, 7, 4, 6, 2, 8};

    initial begin
        int n;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_LOAD; m_tready = 1'b0;
        mismatches = 0; n_loads = 0; n_evals = 0; n_curves = 0;
        phase_num = 0; idle_cnt = 0; hold_cnt = 0; hold_done = 1'b0;
        for (int i = 0; i < NPTS; i++) begin
            pt_x[i] = '0; pt_y[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int p = 0; p < 14; p++) begin
            set_count(counts[p]);
            phase_num = p;
            n = active_points(counts[p]);
            if (p == 0) begin
                // extremes of coordinates and parameter
                for (int i = 0; i < NPTS; i++)
                    push_word(OP_LOAD, i, (i % 2) ? 16'h7fff : 16'h8000,
                              (i % 2) ? 16'h8000 : 16'h7fff, 17'($urandom));
                push_word(OP_EVAL, $urandom_range(7), 16'($urandom), 16'($urandom), '0);
                push_word(OP_EVAL, 0, 16'h0, 16'h0, T_ONE);
                push_word(OP_EVAL, 7, 16'hffff, 16'hffff, T_ONE + 17'd1);
                push_word(OP_EVAL, 0, 16'h0, 16'h0, '1);
                push_word(OP_EVAL, 0, 16'h0, 16'h0, 17'd1);
                push_word(OP_EVAL, 0, 16'h0, 16'h0, 17'h8000);
                continue;
            end
            for (int i = 0; i < n; i++) begin
                push_word(OP_LOAD, i, rand_coord(), rand_coord(), 17'($urandom));
            end
            for (int k = 0; k < 45; k++) begin
                if ($urandom_range(99) < 30)
                    push_word(OP_LOAD, $urandom_range(7), rand_coord(), rand_coord(),
                              17'($urandom));
                else
                    push_word(OP_EVAL, $urandom_range(7), 16'($urandom), 16'($urandom),
                              rand_param());
            end
        end

        while (word_q.size() != 0 || s_tvalid || curve_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("covered %0d loads, %0d evaluates, %0d curve points checked",
                 n_loads, n_evals, n_curves);
        $display("point counts 0 to 15 with saturation, parameter above one, long stall");
        if (mismatches == 0) begin
            $display("PASS bezier_curve_point_evaluator_core");
        end else begin
            $display("FAIL bezier_curve_point_evaluator_core");
        end
        $finish;
    end
endmodule
